// ----- rtl/dfu_pkg.sv -----
// Shared types and constants of the delimited frame unpacker.
package dfu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 8;

  // First payload position: start marker plus three 4-byte header words
  localparam logic [WordW-1:0] HeaderBytes = 32'd13;
  localparam logic [WordW-1:0] PosMax      = '1;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'hAA;
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'h55;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MARKER = 8'd0,
    CFG_END_MARKER   = 8'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_OVERRUN = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             buffer_last;
  } item_t;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic             frame_done;
    status_e          status;
    logic [WordW-1:0] frame_timestamp;
    logic [WordW-1:0] payload_length;
    logic [WordW-1:0] frame_ident;
  } result_t;

endpackage

// ----- rtl/dfu_if.sv -----
// Handshake channel interfaces: received bytes, results and configuration writes.
interface dfu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_last;

  modport source (output valid, output rx_byte, output buffer_last, input ready);
  modport sink   (input valid, input rx_byte, input buffer_last, output ready);
endinterface

interface dfu_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        frame_done;
  logic [1:0]  status;
  logic [31:0] frame_timestamp;
  logic [31:0] payload_length;
  logic [31:0] frame_ident;

  modport source (output valid, output payload_valid, output payload_byte,
                  output frame_done, output status, output frame_timestamp,
                  output payload_length, output frame_ident, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input frame_done, input status, input frame_timestamp,
                  input payload_length, input frame_ident, output ready);
endinterface

interface dfu_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/dfu_in_stage.sv -----
// Input register: holds one accepted byte until the parser hands it on.
module dfu_in_stage
  import dfu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dfu_in_if.sink    rx_i,
  input  logic      advance_i,
  output logic      valid_o,
  output item_t     item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // Take a new byte when empty or when the held one moves on this cycle
  assign rx_i.ready = !valid_q || advance_i;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.rx_byte     <= rx_i.rx_byte;
      item_q.buffer_last <= rx_i.buffer_last;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/dfu_parse.sv -----
// Frame parser: position counter, header shift registers and result logic.
module dfu_parse
  import dfu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [WordW-1:0] pos_q, pos_d;
  logic [WordW-1:0] stamp_q, stamp_d;
  logic [WordW-1:0] length_q, length_d;
  logic [WordW-1:0] ident_q, ident_d;
  logic             start_ok_q, start_ok_d;
  logic             in_payload;
  logic             frame_bad;
  logic [WordW-1:0] byte_ext;

  assign byte_ext   = {{(WordW-ByteW){1'b0}}, item_i.rx_byte};
  assign in_payload = (pos_q >= HeaderBytes) && ((pos_q - HeaderBytes) < length_q);
  assign frame_bad  = (pos_q < HeaderBytes) || !start_ok_q
                      || (item_i.rx_byte != cfg_i.end_marker);

  always_comb begin
    pos_d      = pos_q;
    stamp_d    = stamp_q;
    length_d   = length_q;
    ident_d    = ident_q;
    start_ok_d = start_ok_q;
    result_o   = '0;

    if (item_i.buffer_last) begin
      // Close the frame and drop all collected state
      result_o.frame_done = 1'b1;
      if (frame_bad) begin
        result_o.status = STATUS_INVALID;
      end else begin
        result_o.status          = in_payload ? STATUS_OVERRUN : STATUS_OK;
        result_o.frame_timestamp = stamp_q;
        result_o.payload_length  = length_q;
        result_o.frame_ident     = ident_q;
      end
      pos_d      = '0;
      stamp_d    = '0;
      length_d   = '0;
      ident_d    = '0;
      start_ok_d = 1'b0;
    end else begin
      if (pos_q == '0) begin
        start_ok_d = (item_i.rx_byte == cfg_i.start_marker);
      end else if (pos_q <= 32'd4) begin
        stamp_d = {stamp_q[WordW-ByteW-1:0], item_i.rx_byte};
      end else if (pos_q <= 32'd8) begin
        length_d = {length_q[WordW-ByteW-1:0], item_i.rx_byte};
      end else if (pos_q <= 32'd12) begin
        ident_d = {ident_q[WordW-ByteW-1:0], item_i.rx_byte};
      end
      if (in_payload) begin
        result_o.payload_valid = 1'b1;
        result_o.payload_byte  = byte_ext[ByteW-1:0];
      end
      // Saturate rather than wrap on very long frames
      if (pos_q != PosMax) begin
        pos_d = pos_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      stamp_q    <= '0;
      length_q   <= '0;
      ident_q    <= '0;
      start_ok_q <= 1'b0;
    end else if (advance_i) begin
      pos_q      <= pos_d;
      stamp_q    <= stamp_d;
      length_q   <= length_d;
      ident_q    <= ident_d;
      start_ok_q <= start_ok_d;
    end
  end

endmodule

// ----- rtl/dfu_out_stage.sv -----
// Result register: holds one result until the downstream side takes it.
module dfu_out_stage
  import dfu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  result_t   result_i,
  output logic      space_o,
  dfu_out_if.source res_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign space_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign res_o.valid           = valid_q;
  assign res_o.payload_valid   = result_q.payload_valid;
  assign res_o.payload_byte    = result_q.payload_byte;
  assign res_o.frame_done      = result_q.frame_done;
  assign res_o.status          = result_q.status;
  assign res_o.frame_timestamp = result_q.frame_timestamp;
  assign res_o.payload_length  = result_q.payload_length;
  assign res_o.frame_ident     = result_q.frame_ident;

endmodule

// ----- rtl/delimited_frame_unpacker_top.sv -----
// Top level of the delimited frame unpacker.
//
// Takes one received byte per item and gives exactly one result item per
// byte, in order. A byte passes through an input register, combinational
// parsing logic and a result register. Its result is presented on res_o
// once it is loaded into the result register, which takes it as soon as
// it has room. A new byte is accepted in every cycle while
// results are taken, i.e. one item per cycle sustained. The result register
// is the only stall point: while it holds an untaken result, the input
// register still takes one more byte, and only then does rx_i.ready drop.
// Byte 0 of a frame is checked against start_marker, bytes 1 to 12 are
// shifted in big-endian as timestamp, payload length and frame id, and later
// bytes that are not the buffer's last come out as payload while fewer than
// the declared length have gone out. The byte flagged buffer_last closes the
// frame with frame_done, a status (ok, invalid, or declared payload past
// the buffer) and the header fields, which read zero when the frame is
// invalid. Payload bytes of a bad frame are still passed out; only the
// closing status tells. Markers are written over cfg_i (index 0 start,
// index 1 end, others ignored); cfg_i is always ready and must only be
// written while the block is idle.
module delimited_frame_unpacker_top
  import dfu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dfu_cfg_if.sink   cfg_i,
  dfu_in_if.sink    rx_i,
  dfu_out_if.source res_o
);

  cfg_t    cfg_q, cfg_d;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    out_space;
  logic    advance;

  // Marker registers: always ready, unknown indexes fall through untouched
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_START_MARKER: cfg_d.start_marker = cfg_i.data;
        CFG_END_MARKER:   cfg_d.end_marker   = cfg_i.data;
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= StartMarkerRst;
      cfg_q.end_marker   <= EndMarkerRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Move the held byte on whenever the result register has room
  assign advance = item_valid && out_space;

  dfu_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  dfu_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  dfu_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .space_o  (out_space),
    .res_o    (res_o)
  );

endmodule

// ----- rtl/dfu_checker.sv -----
// Port-level checks on the frame unpacker, bound to the top level.
module dfu_checker
  import dfu_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic        frame_done,
  input logic [1:0]  status,
  input logic [31:0] frame_timestamp,
  input logic [31:0] payload_length,
  input logic [31:0] frame_ident
);

  // A stalled result keeps its payload, payload_valid, frame_done and status
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(payload_byte)
      && $stable(frame_done) && $stable(status) && $stable(payload_valid))
    else $error("result changed while stalled");

  // The closing byte is never payload
  a_done_not_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && frame_done |-> !payload_valid)
    else $error("payload flagged on frame close");

  // Mid-frame results carry no status and no header
  a_mid_frame_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !frame_done |-> status == STATUS_OK && frame_timestamp == '0
      && payload_length == '0 && frame_ident == '0)
    else $error("status or header on mid-frame result");

  // An invalid frame shows no header
  a_invalid_no_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && frame_done && status == STATUS_INVALID |-> frame_timestamp == '0
      && payload_length == '0 && frame_ident == '0)
    else $error("header shown for invalid frame");

endmodule

bind delimited_frame_unpacker_top dfu_checker u_dfu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid       (res_o.valid),
  .res_ready       (res_o.ready),
  .payload_valid   (res_o.payload_valid),
  .payload_byte    (res_o.payload_byte),
  .frame_done      (res_o.frame_done),
  .status          (res_o.status),
  .frame_timestamp (res_o.frame_timestamp),
  .payload_length  (res_o.payload_length),
  .frame_ident     (res_o.frame_ident)
);
